@@ design/fips_pkg.sv @@
// Shared types, constants and coefficient helpers for the fern point stepper.
package fips_pkg;

    // Widths of the fixed fields on the ports.
    localparam int RAND_W = 16;
    localparam int THR_W = 16;
    localparam int PIXEL_W = 10;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    // Reset values of the thresholds, in units of 1/65536.
    localparam logic [THR_W-1:0] STEM_THR_RESET = 16'd655;
    localparam logic [THR_W-1:0] MAIN_THR_RESET = 16'd56361;
    localparam logic [THR_W-1:0] LEFT_THR_RESET = 16'd60948;

    // Queue between the classifier and the execution pipeline.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Division by ten through a reciprocal, exact for every 16-bit dividend.
    localparam int DIV_W = 16;
    localparam int DIV10_MULT = 52429;
    localparam int DIV10_SHIFT = 19;

    // Affine maps: x' = xx*x + xy*y, y' = yx*x + yy*y + y0, in hundredths.
    localparam int MAP_COUNT = 4;
    localparam int TERM_COUNT = 5;
    localparam int TERM_XX = 0;
    localparam int TERM_XY = 1;
    localparam int TERM_YX = 2;
    localparam int TERM_YY = 3;
    localparam int TERM_Y0 = 4;

    localparam int MAP_COEF [MAP_COUNT][TERM_COUNT] = '{
        '{  0,   0,   0,  16,   0},
        '{ 85,   4,  -4,  85, 160},
        '{ 20, -26,  23,  22, 160},
        '{-15,  28,  26,  24,  44}
    };

    typedef enum logic [1:0] {
        MAP_STEM,
        MAP_MAIN,
        MAP_LEFT,
        MAP_RIGHT
    } map_t;

    typedef enum logic [1:0] {
        REG_STEM,
        REG_MAIN,
        REG_LEFT
    } reg_index_t;

    // Word pushed by the classifier into the queue.
    typedef struct packed {
        logic valid;
        map_t map_sel;
    } push_t;

    // Queue occupancy seen by the front and by the top level.
    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } queue_status_t;

    // Coefficient in hundredths scaled by 2^frac_bits, rounded half away from zero.
    function automatic longint quant_coef(int hundredths, int frac_bits);
        longint one;
        longint mag;
        one = longint'(1) << frac_bits;
        if (hundredths < 0) begin
            mag = (longint'(-hundredths) * one + 50) / 100;
            return -mag;
        end
        mag = (longint'(hundredths) * one + 50) / 100;
        return mag;
    endfunction

endpackage

@@ design/fern_ifs_point_step.sv @@
// Throughput: one word per cycle unless the output stalls; the limit is the point
// recurrence, which closes through the two coefficient multiplies per coordinate
// of the update stage. A word passes the queue, registers a and b, then the output.
// Reset (synchronous, aresetn low): point returns to (0, 0), thresholds to their
// defaults, and the queue and all pipeline valids are cleared.
module fern_ifs_point_step #(
    parameter int IMAGE_WIDTH = 800,
    parameter int IMAGE_HEIGHT = 600,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [fips_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [fips_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [fips_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [fips_pkg::RAND_W-1:0]          s_random_fraction,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [fips_pkg::PIXEL_W-1:0]         m_pixel_column,
    output logic [fips_pkg::PIXEL_W-1:0]         m_pixel_row,
    output logic [1:0]                           m_map_used
);

    logic [fips_pkg::THR_W-1:0]  stem_thr_reg;
    logic [fips_pkg::THR_W-1:0]  main_thr_reg;
    logic [fips_pkg::THR_W-1:0]  left_thr_reg;
    fips_pkg::reg_index_t        reg_index;
    logic                        cfg_write;
    fips_pkg::push_t             push;
    fips_pkg::queue_status_t     q_status;
    fips_pkg::map_t              q_map;
    logic                        pop;

    // Register file on the configuration port.
    assign pready = 1'b1;
    assign reg_index = fips_pkg::reg_index_t'(paddr[3:2]);
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stem_thr_reg <= fips_pkg::STEM_THR_RESET;
            main_thr_reg <= fips_pkg::MAIN_THR_RESET;
            left_thr_reg <= fips_pkg::LEFT_THR_RESET;
        end else if (cfg_write) begin
            case (reg_index)
                fips_pkg::REG_STEM: begin
                    stem_thr_reg <= pwdata[fips_pkg::THR_W-1:0];
                end
                fips_pkg::REG_MAIN: begin
                    main_thr_reg <= pwdata[fips_pkg::THR_W-1:0];
                end
                fips_pkg::REG_LEFT: begin
                    left_thr_reg <= pwdata[fips_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            fips_pkg::REG_STEM: prdata = fips_pkg::APB_DATA_W'(stem_thr_reg);
            fips_pkg::REG_MAIN: prdata = fips_pkg::APB_DATA_W'(main_thr_reg);
            fips_pkg::REG_LEFT: prdata = fips_pkg::APB_DATA_W'(left_thr_reg);
            default:            prdata = '0;
        endcase
    end

    // Classifier, queue and execution pipeline.
    fips_front u_front (
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_random_fraction (s_random_fraction),
        .stem_threshold    (stem_thr_reg),
        .main_threshold    (main_thr_reg),
        .left_threshold    (left_thr_reg),
        .q_status          (q_status),
        .push              (push)
    );

    fips_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .pop      (pop),
        .q_map    (q_map),
        .q_status (q_status)
    );

    fips_back #(
        .IMAGE_WIDTH   (IMAGE_WIDTH),
        .IMAGE_HEIGHT  (IMAGE_HEIGHT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (~q_status.empty),
        .q_map          (q_map),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_column (m_pixel_column),
        .m_pixel_row    (m_pixel_row),
        .m_map_used     (m_map_used)
    );

    // The queue never holds more words than its depth.
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.count <= fips_pkg::QCNT_W'(fips_pkg::QUEUE_DEPTH))
        else $error("queue occupancy above its depth");

    // The pipeline only takes a word that the queue holds.
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("pop from an empty queue");

    // A pushed word lands in the queue by the next cycle.
    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |=> !q_status.empty)
        else $error("pushed word missing from the queue");

    // Column stays inside the image when the image fits the field.
    a_column_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (IMAGE_WIDTH > 1024) ||
                    (m_pixel_column <= fips_pkg::PIXEL_W'(IMAGE_WIDTH - 1)))
        else $error("pixel column beyond image width");

endmodule

@@ design/fips_front.sv @@
// Front end: accepts random words and picks the affine map for each.
module fips_front (
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [fips_pkg::RAND_W-1:0]        s_random_fraction,
    input  logic [fips_pkg::THR_W-1:0]         stem_threshold,
    input  logic [fips_pkg::THR_W-1:0]         main_threshold,
    input  logic [fips_pkg::THR_W-1:0]         left_threshold,
    input  fips_pkg::queue_status_t            q_status,
    output fips_pkg::push_t                    push
);

    fips_pkg::map_t map_sel;

    // Cascaded threshold compare; an empty interval is never chosen.
    always_comb begin
        if (s_random_fraction < stem_threshold) begin
            map_sel = fips_pkg::MAP_STEM;
        end else if (s_random_fraction < main_threshold) begin
            map_sel = fips_pkg::MAP_MAIN;
        end else if (s_random_fraction < left_threshold) begin
            map_sel = fips_pkg::MAP_LEFT;
        end else begin
            map_sel = fips_pkg::MAP_RIGHT;
        end
    end

    // A word is taken whenever the queue has room.
    assign s_ready = ~q_status.full;
    assign push.valid = s_valid & ~q_status.full;
    assign push.map_sel = map_sel;

endmodule

@@ design/fips_queue.sv @@
// Small FIFO of map selections between the front end and the pipeline.
module fips_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  fips_pkg::push_t         push,
    input  logic                    pop,
    output fips_pkg::map_t          q_map,
    output fips_pkg::queue_status_t q_status
);

    fips_pkg::map_t                     entry_reg [fips_pkg::QUEUE_DEPTH];
    logic [fips_pkg::QPTR_W-1:0]        wptr_reg;
    logic [fips_pkg::QPTR_W-1:0]        rptr_reg;
    logic [fips_pkg::QCNT_W-1:0]        count_reg;
    logic [fips_pkg::QCNT_W-1:0]        count_next;

    // Occupancy follows pushes and pops; the depth is a power of two so pointers wrap.
    always_comb begin
        count_next = count_reg;
        if (push.valid && !pop) begin
            count_next = count_reg + fips_pkg::QCNT_W'(1);
        end else if (!push.valid && pop) begin
            count_next = count_reg - fips_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (push.valid) begin
                wptr_reg <= wptr_reg + fips_pkg::QPTR_W'(1);
            end
            if (pop) begin
                rptr_reg <= rptr_reg + fips_pkg::QPTR_W'(1);
            end
        end
    end

    // Storage needs no reset; entries are read only once written.
    always_ff @(posedge aclk) begin
        if (push.valid) begin
            entry_reg[wptr_reg] <= push.map_sel;
        end
    end

    assign q_map = entry_reg[rptr_reg];
    assign q_status.full = (count_reg == fips_pkg::QCNT_W'(fips_pkg::QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign q_status.count = count_reg;

endmodule

@@ design/fips_back.sv @@
// Execution pipeline: affine point update, pixel scaling and the output register.
module fips_back #(
    parameter int IMAGE_WIDTH = 800,
    parameter int IMAGE_HEIGHT = 600,
    parameter int FRACTION_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  fips_pkg::map_t                 q_map,
    output logic                           pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [fips_pkg::PIXEL_W-1:0]   m_pixel_column,
    output logic [fips_pkg::PIXEL_W-1:0]   m_pixel_row,
    output logic [1:0]                     m_map_used
);

    // Point state, coefficients and accumulator widths.
    localparam int SW = FRACTION_BITS + 6;
    localparam int CW = FRACTION_BITS + 2;
    localparam int AW = SW + CW + 2;
    localparam int MAX_SIZE = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
    localparam int SZW = $clog2(MAX_SIZE + 1);
    localparam int PW = SW + SZW;
    localparam int QW = PW - FRACTION_BITS;
    localparam int PXW = fips_pkg::PIXEL_W;

    localparam logic signed [AW-1:0] ROUND_HALF = AW'(longint'(1) << (FRACTION_BITS - 1));
    localparam logic signed [AW-1:0] SAT_HI = {{(AW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
    localparam logic signed [AW-1:0] SAT_LO = {{(AW - SW + 1){1'b1}}, {(SW - 1){1'b0}}};
    localparam logic signed [SW:0] X_SHIFT = (SW + 1)'(longint'(5) << FRACTION_BITS);
    localparam logic [QW-1:0] COL_LIMIT = QW'(10 * IMAGE_WIDTH);
    localparam logic [QW-1:0] ROW_LIMIT = QW'(10 * IMAGE_HEIGHT);
    localparam logic [PXW-1:0] COL_TOP = PXW'(IMAGE_WIDTH - 1);
    localparam logic [PXW-1:0] ROW_TOP = PXW'(IMAGE_HEIGHT - 1);

    logic signed [CW-1:0] k_xx_tab [fips_pkg::MAP_COUNT];
    logic signed [CW-1:0] k_xy_tab [fips_pkg::MAP_COUNT];
    logic signed [CW-1:0] k_yx_tab [fips_pkg::MAP_COUNT];
    logic signed [CW-1:0] k_yy_tab [fips_pkg::MAP_COUNT];
    logic signed [CW-1:0] k_y0_tab [fips_pkg::MAP_COUNT];

    logic                  advance;
    logic signed [CW-1:0]  k_xx;
    logic signed [CW-1:0]  k_xy;
    logic signed [CW-1:0]  k_yx;
    logic signed [CW-1:0]  k_yy;
    logic signed [CW-1:0]  k_y0;
    logic signed [AW-1:0]  acc_x;
    logic signed [AW-1:0]  acc_y;
    logic signed [AW-1:0]  sum_x;
    logic signed [AW-1:0]  sum_y;
    logic signed [SW-1:0]  point_x_next;
    logic signed [SW-1:0]  point_y_next;
    logic signed [SW:0]    off_x;

    logic                  a_valid_reg;
    fips_pkg::map_t        a_map_reg;
    logic signed [SW-1:0]  point_x_reg;
    logic signed [SW-1:0]  point_y_reg;

    logic                  b_valid_reg;
    fips_pkg::map_t        b_map_reg;
    logic [PW-1:0]         b_prod_col_reg;
    logic [PW-1:0]         b_prod_row_reg;
    logic                  b_col_zero_reg;
    logic                  b_row_zero_reg;

    logic                  out_valid_reg;
    logic [PXW-1:0]        out_col_reg;
    logic [PXW-1:0]        out_row_reg;
    fips_pkg::map_t        out_map_reg;

    // Coefficients of the four maps in the point's fixed-point format.
    for (genvar i = 0; i < fips_pkg::MAP_COUNT; i++) begin : g_coef
        assign k_xx_tab[i] = CW'(fips_pkg::quant_coef(
            fips_pkg::MAP_COEF[i][fips_pkg::TERM_XX], FRACTION_BITS));
        assign k_xy_tab[i] = CW'(fips_pkg::quant_coef(
            fips_pkg::MAP_COEF[i][fips_pkg::TERM_XY], FRACTION_BITS));
        assign k_yx_tab[i] = CW'(fips_pkg::quant_coef(
            fips_pkg::MAP_COEF[i][fips_pkg::TERM_YX], FRACTION_BITS));
        assign k_yy_tab[i] = CW'(fips_pkg::quant_coef(
            fips_pkg::MAP_COEF[i][fips_pkg::TERM_YY], FRACTION_BITS));
        assign k_y0_tab[i] = CW'(fips_pkg::quant_coef(
            fips_pkg::MAP_COEF[i][fips_pkg::TERM_Y0], FRACTION_BITS));
    end

    // Scales a registered product to a pixel: divide by ten times 2^FRACTION_BITS, clamp.
    function automatic logic [PXW-1:0] to_pixel(logic zero, logic [PW-1:0] prod,
                                                 logic [QW-1:0] limit, logic [PXW-1:0] top);
        logic [QW-1:0]          q;
        logic [2*fips_pkg::DIV_W-1:0] scaled;
        q = prod[PW-1:FRACTION_BITS];
        scaled = (2 * fips_pkg::DIV_W)'(fips_pkg::DIV_W'(q))
               * (2 * fips_pkg::DIV_W)'(fips_pkg::DIV10_MULT);
        if (zero) begin
            return '0;
        end
        if (q >= limit) begin
            return top;
        end
        return PXW'(scaled >> fips_pkg::DIV10_SHIFT);
    endfunction

    // The whole pipeline moves when the output register is free or being taken.
    assign advance = ~out_valid_reg | m_ready;
    assign pop = q_valid & advance;

    // Point update: two products per coordinate, round half up, add the y offset, saturate.
    always_comb begin
        k_xx = k_xx_tab[q_map];
        k_xy = k_xy_tab[q_map];
        k_yx = k_yx_tab[q_map];
        k_yy = k_yy_tab[q_map];
        k_y0 = k_y0_tab[q_map];
        acc_x = AW'(k_xx) * AW'(point_x_reg) + AW'(k_xy) * AW'(point_y_reg) + ROUND_HALF;
        acc_y = AW'(k_yx) * AW'(point_x_reg) + AW'(k_yy) * AW'(point_y_reg) + ROUND_HALF;
        sum_x = acc_x >>> FRACTION_BITS;
        sum_y = (acc_y >>> FRACTION_BITS) + AW'(k_y0);
        if (sum_x > SAT_HI) begin
            point_x_next = SW'(SAT_HI);
        end else if (sum_x < SAT_LO) begin
            point_x_next = SW'(SAT_LO);
        end else begin
            point_x_next = SW'(sum_x);
        end
        if (sum_y > SAT_HI) begin
            point_y_next = SW'(SAT_HI);
        end else if (sum_y < SAT_LO) begin
            point_y_next = SW'(SAT_LO);
        end else begin
            point_y_next = SW'(sum_y);
        end
    end

    // Column offset: the domain starts at x = -5.
    assign off_x = (SW + 1)'(point_x_reg) + X_SHIFT;

    // Control of the three stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            point_x_reg   <= '0;
            point_y_reg   <= '0;
        end else if (advance) begin
            a_valid_reg   <= pop;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
            if (pop) begin
                point_x_reg <= point_x_next;
                point_y_reg <= point_y_next;
            end
        end
    end

    // Payload of the three stages.
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (pop) begin
                a_map_reg <= q_map;
            end
            b_map_reg      <= a_map_reg;
            b_col_zero_reg <= off_x[SW] | (off_x == '0);
            b_row_zero_reg <= point_y_reg[SW-1] | (point_y_reg == '0);
            b_prod_col_reg <= PW'(off_x[SW-1:0]) * PW'(IMAGE_WIDTH);
            b_prod_row_reg <= PW'($unsigned(point_y_reg)) * PW'(IMAGE_HEIGHT);
            out_map_reg    <= b_map_reg;
            out_col_reg    <= to_pixel(b_col_zero_reg, b_prod_col_reg, COL_LIMIT, COL_TOP);
            out_row_reg    <= to_pixel(b_row_zero_reg, b_prod_row_reg, ROW_LIMIT, ROW_TOP);
        end
    end

    assign m_valid = out_valid_reg;
    assign m_pixel_column = out_col_reg;
    assign m_pixel_row = out_row_reg;
    assign m_map_used = out_map_reg;

endmodule

@@ tb/tb_fern_ifs_point_step.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the fern point stepper: random fraction words in, pixel words out.
module tb_fern_ifs_point_step;
    import fips_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int POINT_BITS = FRAC_BITS + 6;
    localparam int IMG_W = 800;
    localparam int IMG_H = 600;
    localparam int THR_COUNT = 3;
    localparam int UNUSED_REG = 3;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS = 10;
    localparam logic [THR_W-1:0] STEM_DEFAULT = 16'd655;
    localparam logic [THR_W-1:0] MAIN_DEFAULT = 16'd56361;
    localparam logic [THR_W-1:0] LEFT_DEFAULT = 16'd60948;

    // Fern map terms in hundredths, indexed by map and then by term.
    localparam int FERN_TERMS [4][5] = '{
        '{  0,   0,   0,  16,   0},
        '{ 85,   4,  -4,  85, 160},
        '{ 20, -26,  23,  22, 160},
        '{-15,  28,  26,  24,  44}
    };

    typedef struct {
        logic [PIXEL_W-1:0] column;
        logic [PIXEL_W-1:0] row;
        map_t               map_sel;
    } pixel_word_t;

    typedef enum int {
        RX_STEADY,
        RX_RANDOM,
        RX_PATTERN,
        RX_BURSTY
    } stall_style_t;

    // Tracks the fern point and the thresholds, and holds the pixel words still due.
    class fern_point_tracker;
        logic [THR_W-1:0] threshold [THR_COUNT];
        longint           point_x;
        longint           point_y;
        pixel_word_t      pending [$];
        int               failures;

        function new();
            threshold[REG_STEM] = STEM_DEFAULT;
            threshold[REG_MAIN] = MAIN_DEFAULT;
            threshold[REG_LEFT] = LEFT_DEFAULT;
            point_x = 0;
            point_y = 0;
            failures = 0;
        endfunction

        function void log_failure(string msg);
            failures++;
            if (failures <= MAX_REPORTS) begin
                $display("ERROR at %0t: %s", $time, msg);
            end
        endfunction

        // Writes to an index past the last threshold are dropped.
        function void write_threshold(int index, logic [APB_DATA_W-1:0] value);
            if (index < THR_COUNT) begin
                threshold[index] = value[THR_W-1:0];
            end
        endfunction

        // Hundredths to fixed point, ties rounded away from zero.
        function longint to_fixed(int hundredths);
            longint mag;
            mag = (longint'(hundredths < 0 ? -hundredths : hundredths)
                   * (longint'(1) << FRAC_BITS) + 50) / 100;
            return (hundredths < 0) ? -mag : mag;
        endfunction

        // One coordinate of the update: exact sum, round half up, offset, saturate.
        function longint next_coord(int kx, int ky, int k0, longint x, longint y);
            longint acc;
            longint lim;
            acc = to_fixed(kx) * x + to_fixed(ky) * y + (longint'(1) << (FRAC_BITS - 1));
            acc = (acc >>> FRAC_BITS) + to_fixed(k0);
            lim = longint'(1) << (POINT_BITS - 1);
            if (acc > lim - 1) begin
                return lim - 1;
            end
            if (acc < -lim) begin
                return -lim;
            end
            return acc;
        endfunction

        // Offset across a domain ten units wide, scaled to the image and clamped.
        function logic [PIXEL_W-1:0] to_pixel(longint offset, int size);
            longint p;
            if (offset <= 0) begin
                return '0;
            end
            p = offset * size / (longint'(10) << FRAC_BITS);
            if (p > size - 1) begin
                p = size - 1;
            end
            return p[PIXEL_W-1:0];
        endfunction

        function void note_fraction(logic [RAND_W-1:0] fraction);
            map_t        m;
            int          k;
            longint      nx;
            longint      ny;
            pixel_word_t w;
            if (fraction < threshold[REG_STEM]) begin
                m = MAP_STEM;
            end else if (fraction < threshold[REG_MAIN]) begin
                m = MAP_MAIN;
            end else if (fraction < threshold[REG_LEFT]) begin
                m = MAP_LEFT;
            end else begin
                m = MAP_RIGHT;
            end
            k = int'(m);
            nx = next_coord(FERN_TERMS[k][TERM_XX], FERN_TERMS[k][TERM_XY], 0,
                            point_x, point_y);
            ny = next_coord(FERN_TERMS[k][TERM_YX], FERN_TERMS[k][TERM_YY],
                            FERN_TERMS[k][TERM_Y0], point_x, point_y);
            point_x = nx;
            point_y = ny;
            w.column = to_pixel(nx + (longint'(5) << FRAC_BITS), IMG_W);
            w.row = to_pixel(ny, IMG_H);
            w.map_sel = m;
            pending.push_back(w);
        endfunction

        function void check_pixel(logic [PIXEL_W-1:0] column, logic [PIXEL_W-1:0] row,
                                  logic [1:0] map_bits);
            pixel_word_t w;
            if (pending.size() == 0) begin
                log_failure($sformatf("unexpected result word: col=%0d row=%0d map=%0d",
                                      column, row, map_bits));
                return;
            end
            w = pending.pop_front();
            if (column !== w.column || row !== w.row || map_bits !== w.map_sel) begin
                log_failure($sformatf(
                    "pixel mismatch: expected col=%0d row=%0d map=%0d, got col=%0d row=%0d map=%0d",
                    w.column, w.row, w.map_sel, column, row, map_bits));
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [RAND_W-1:0]     s_random_fraction = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [PIXEL_W-1:0]    m_pixel_column;
    logic [PIXEL_W-1:0]    m_pixel_row;
    logic [1:0]            m_map_used;

    fern_point_tracker tracker = new();

    stall_style_t stall_style = RX_STEADY;
    int           stall_cycle = 0;
    int           stall_left = 0;

    fern_ifs_point_step dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_random_fraction (s_random_fraction),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pixel_column    (m_pixel_column),
        .m_pixel_row       (m_pixel_row),
        .m_map_used        (m_map_used)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Both handshakes are sampled at the clock edge, before any update of that edge lands.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                tracker.note_fraction(s_random_fraction);
            end
            if (m_valid && m_ready) begin
                tracker.check_pixel(m_pixel_column, m_pixel_row, m_map_used);
            end
        end
    end

    // The receiver switches at random among steady, random, patterned and bursty stall styles.
    always @(posedge aclk) begin
        stall_cycle <= stall_cycle + 1;
        if (stall_cycle % 200 == 0) begin
            stall_style <= stall_style_t'($urandom_range(0, 3));
        end
        case (stall_style)
            RX_STEADY: begin
                m_ready <= 1'b1;
            end
            RX_RANDOM: begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end
            RX_PATTERN: begin
                m_ready <= ((stall_cycle % 11) < 6);
            end
            default: begin
                if (stall_left != 0) begin
                    stall_left <= stall_left - 1;
                    m_ready <= 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    stall_left <= $urandom_range(4, 24);
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        endcase
    end

    // Offers one word and returns at the edge that accepts it; valid stays high.
    task automatic send_word(input logic [RAND_W-1:0] fraction);
        s_valid <= 1'b1;
        s_random_fraction <= fraction;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Mostly uniform fractions, the rest clustered around the current thresholds.
    function automatic logic [RAND_W-1:0] pick_fraction();
        int v;
        if ($urandom_range(0, 3) != 0) begin
            return RAND_W'($urandom);
        end
        v = int'(tracker.threshold[$urandom_range(0, THR_COUNT - 1)])
            + int'($urandom_range(0, 4)) - 2;
        if (v < 0) begin
            v = 0;
        end
        if (v > 65535) begin
            v = 65535;
        end
        return v[RAND_W-1:0];
    endfunction

    // Sends words in bursts of random length, with random gaps when asked.
    task automatic feed_fractions(input int count, input bit gappy);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && sent < count; k++) begin
                send_word(pick_fraction());
                sent++;
            end
            gap = gappy ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;
    endtask

    // Waits until every pixel word is back, then lets the pipeline settle.
    // The first edge lets the monitor note a word accepted at the edge just passed.
    task automatic drain_results();
        @(posedge aclk);
        while (tracker.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input int index, input logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(index * 4);
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_read(input int index, output logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= APB_ADDR_W'(index * 4);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        data = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Reads every threshold back and compares it with the tracked value.
    task automatic verify_thresholds();
        logic [APB_DATA_W-1:0] data;
        for (int i = 0; i < THR_COUNT; i++) begin
            apb_read(i, data);
            if (data[THR_W-1:0] !== tracker.threshold[i]) begin
                tracker.log_failure($sformatf("threshold %0d reads %0d, expected %0d",
                                              i, data[THR_W-1:0], tracker.threshold[i]));
            end
        end
    endtask

    // Reprograms all three thresholds on an idle block, then streams a batch of words.
    task automatic run_phase(input int stem, input int main, input int left,
                             input int count, input bit gappy);
        logic [APB_DATA_W-1:0] word;
        drain_results();
        word = {16'($urandom), 16'(stem)};
        apb_write(REG_STEM, word);
        tracker.write_threshold(REG_STEM, word);
        word = {16'($urandom), 16'(main)};
        apb_write(REG_MAIN, word);
        tracker.write_threshold(REG_MAIN, word);
        word = {16'($urandom), 16'(left)};
        apb_write(REG_LEFT, word);
        tracker.write_threshold(REG_LEFT, word);
        verify_thresholds();
        feed_fractions(count, gappy);
    endtask

    initial begin
        logic [RAND_W-1:0] boundary_words [$];
        int                trio [$];
        logic [APB_DATA_W-1:0] spare;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        verify_thresholds();

        // A run of main-map steps moves the point away from the origin, then the
        // fraction extremes and both sides of every default threshold follow.
        boundary_words = '{16'd0, 16'd65535, 16'd654, 16'd655, 16'd56360, 16'd56361,
                           16'd60947, 16'd60948, 16'h5555, 16'hAAAA};
        repeat (15) send_word(16'd30000);
        foreach (boundary_words[i]) begin
            send_word(boundary_words[i]);
        end
        feed_fractions(375, 1'b1);

        // Threshold extremes: everything to the right leaflet, then nearly all stem.
        run_phase(0, 0, 0, 100, 1'b1);
        run_phase(65535, 65535, 65535, 100, 1'b0);

        // Unordered thresholds leave the main and left intervals empty.
        run_phase(40000, 20000, 30000, 150, 1'b1);

        trio = '{int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)),
                 int'($urandom_range(0, 65535))};
        trio.sort();
        run_phase(trio[0], trio[1], trio[2], 200, 1'b1);

        // A write past the last register must leave the thresholds alone.
        drain_results();
        spare = $urandom;
        apb_write(UNUSED_REG, spare);
        tracker.write_threshold(UNUSED_REG, spare);
        run_phase($urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), 150, 1'b1);

        run_phase(STEM_DEFAULT, MAIN_DEFAULT, LEFT_DEFAULT, 150, 1'b1);
        drain_results();

        if (tracker.failures == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
design/fips_pkg.sv
design/fips_front.sv
design/fips_queue.sv
design/fips_back.sv
design/fern_ifs_point_step.sv
tb/tb_fern_ifs_point_step.sv
